@@ sv/uprs_pkg.sv @@
// Package for the uniform polyline resampler.
// Holds widths, limits and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package uprs_pkg;

  localparam int CoordW      = 32;
  localparam int SpacingW    = 31;
  localparam int LenW        = 33;
  localparam int RadW        = 66;
  localparam int RemW        = 35;
  localparam int DirBits     = 30;
  localparam int QW          = DirBits + 1;
  localparam int UsedW       = 34;
  localparam int MulAW       = 32;
  localparam int MulBW       = 17;
  localparam int ProdW       = MulAW + MulBW;
  localparam int CntW        = 6;
  localparam int MaxSamples  = 63;
  localparam int RootSteps   = RadW / 2;
  localparam int DivSteps    = QW;

  localparam logic [SpacingW-1:0] SpacingReset = SpacingW'(65536);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQR   = 8'b0000_0010,
    ST_ROOT  = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_CNT   = 8'b0001_0000,
    ST_GEN   = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_FLUSH = 8'b1000_0000
  } state_e;

endpackage

@@ sv/uprs_mul.sv @@
// Shared registered multiplier of the resampler, 32 x 17 bits unsigned.
// Depends on uprs_pkg for operand widths.
`timescale 1ns / 1ps

module uprs_mul (
  input  logic                        clk_i,
  input  logic [uprs_pkg::MulAW-1:0]  a_i,
  input  logic [uprs_pkg::MulBW-1:0]  b_i,
  output logic [uprs_pkg::ProdW-1:0]  p_o
);
  import uprs_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ sv/uniform_polyline_resampler_unit.sv @@
// Top level of the uniform polyline resampler: sequencer, sqrt, divider and output stage.
// Depends on uprs_pkg and uprs_mul.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  in       | in_valid_i / in_ready_o     | point_x_i, point_y_i, last_point_i
//  out      | out_valid_o / out_ready_i   | res_x_o, res_y_o, run_end_o,
//           |                             | path_end_o, overflow_o
//  cfg      | cfg_we_i                    | cfg_wdata_i (sample_spacing)
//
// After acceptance a segment vertex runs squaring, sqrt, the divider per axis, count pass,
// sample generation, finish and flush; a zero-length segment leaves the divider for finish.
// The sqrt retires one bit a cycle, the divider one bit a cycle per axis, each sample uses
// the shared multiplier 4 times. First vertex and pass-through go from idle to finish.
// in_ready_o is high only when idle. A result held in the pending or output register
// stalls the sequencer until taken. Reset clears control state and loads spacing with 1.0 m.
`timescale 1ns / 1ps

module uniform_polyline_resampler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [uprs_pkg::CoordW-1:0] point_x_i,
  input  logic signed [uprs_pkg::CoordW-1:0] point_y_i,
  input  logic                              last_point_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [uprs_pkg::CoordW-1:0] res_x_o,
  output logic signed [uprs_pkg::CoordW-1:0] res_y_o,
  output logic                              run_end_o,
  output logic                              path_end_o,
  output logic                              overflow_o,
  input  logic                              cfg_we_i,
  input  logic [uprs_pkg::SpacingW-1:0]     cfg_wdata_i
);
  import uprs_pkg::*;

  state_e state_q, state_d;

  logic [SpacingW-1:0] spacing_q;
  logic                started_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic signed [CoordW-1:0] emit_x_q, emit_y_q;
  logic                last_q;
  logic [SpacingW-1:0] owed_q, new_owed_q;
  logic [CoordW-1:0]   ax_q, ay_q;
  logic                negx_q, negy_q;
  logic [RadW-1:0]     acc_q;
  logic [RemW-1:0]     rem_q;
  logic [LenW-1:0]     len_q;
  logic [QW-1:0]       qx_q, qy_q, qt_q;
  logic                axis_q;
  logic [2:0]          sub_q;
  logic [CntW-1:0]     stp_q, cnt_q, idx_q;
  logic [UsedW-1:0]    used_q;
  logic                ovf_q;
  logic signed [CoordW-1:0] sx_q, sy_q;

  logic signed [CoordW-1:0] pend_x_q, pend_y_q;
  logic                pend_v_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic                out_v_q, out_re_q, out_pe_q, out_ovf_q;

  logic [MulAW-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [ProdW-1:0]    prod;

  uprs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // push / flush into the pending and output registers
  logic push_req, flush_req, out_free, push_done, flush_done, move;
  logic signed [CoordW-1:0] push_x, push_y;

  logic in_acc;
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);

  // input differences
  logic signed [CoordW:0] dx, dy, adx, ady;
  assign dx  = {point_x_i[CoordW-1], point_x_i} - {prev_x_q[CoordW-1], prev_x_q};
  assign dy  = {point_y_i[CoordW-1], point_y_i} - {prev_y_q[CoordW-1], prev_y_q};
  assign adx = dx[CoordW] ? -dx : dx;
  assign ady = dy[CoordW] ? -dy : dy;

  // sqrt step
  logic [RemW+1:0] rt_t, rt_trial;
  logic            rt_ge;
  assign rt_t     = {rem_q, acc_q[RadW-1 -: 2]};
  assign rt_trial = (RemW+2)'({len_q, 2'b01});
  assign rt_ge    = rt_t >= rt_trial;

  // divider step
  logic [RemW-1:0] dv_t;
  logic            dv_ge;
  assign dv_t  = (stp_q == '0) ? RemW'(axis_q ? ay_q : ax_q) : {rem_q[RemW-2:0], 1'b0};
  assign dv_ge = dv_t >= RemW'(len_q);

  // count pass
  logic [SpacingW-1:0] owed_cur;
  logic [UsedW-1:0]    nxt;
  logic                fits;
  logic [LenW-1:0]     left;
  assign owed_cur = (cnt_q == '0) ? owed_q : spacing_q;
  assign nxt      = used_q + UsedW'(owed_cur);
  assign fits     = nxt <= UsedW'(len_q);
  assign left     = len_q - used_q[LenW-1:0];

  // sample offset
  logic [63:0]            psum, prnd;
  logic [CoordW-1:0]      off;
  logic signed [CoordW:0] base, along;
  logic                   neg;
  assign psum  = acc_q[63:0] + 64'({prod, 17'b0});
  assign prnd  = psum + (64'd1 << (DirBits - 1));
  assign off   = prnd[DirBits +: CoordW];
  assign neg   = (sub_q == 3'd2) ? negx_q : negy_q;
  assign base  = (sub_q == 3'd2) ? {prev_x_q[CoordW-1], prev_x_q}
                                 : {prev_y_q[CoordW-1], prev_y_q};
  assign along = neg ? base - $signed({1'b0, off}) : base + $signed({1'b0, off});

  logic smp_diff, fin_diff;
  assign smp_diff = (sx_q != emit_x_q) || (sy_q != emit_y_q);
  assign fin_diff = (cur_x_q != emit_x_q) || (cur_y_q != emit_y_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQR) begin
      mul_a = sub_q[1] ? ay_q : ax_q;
      mul_b = sub_q[0] ? MulBW'((sub_q[1] ? ay_q : ax_q) >> MulBW)
                       : (sub_q[1] ? ay_q[MulBW-1:0] : ax_q[MulBW-1:0]);
    end else if (state_q == ST_GEN) begin
      mul_a = MulAW'(sub_q[1] ? qy_q : qx_q);
      mul_b = sub_q[0] ? MulBW'(used_q[LenW-1:MulBW]) : used_q[MulBW-1:0];
    end
  end

  always_comb begin
    push_req  = 1'b0;
    flush_req = 1'b0;
    push_x    = point_x_i;
    push_y    = point_y_i;
    unique case (state_q)
      ST_IDLE: begin
        push_req = in_acc && (!started_q || spacing_q == '0);
      end
      ST_GEN: begin
        push_req = (sub_q == 3'd5) && smp_diff;
        push_x   = sx_q;
        push_y   = sy_q;
      end
      ST_FIN: begin
        push_req = last_q && fin_diff;
        push_x   = cur_x_q;
        push_y   = cur_y_q;
      end
      ST_FLUSH: flush_req = 1'b1;
      default: ;
    endcase
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign push_done  = push_req && (!pend_v_q || out_free);
  assign flush_done = flush_req && (!pend_v_q || out_free);
  assign move       = pend_v_q && out_free && (push_req || flush_req);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) begin
        state_d = (!started_q || spacing_q == '0) ? ST_FIN : ST_SQR;
      end
      ST_SQR:   if (sub_q == 3'd4) state_d = ST_ROOT;
      ST_ROOT:  if (stp_q == CntW'(RootSteps - 1)) state_d = ST_DIV;
      ST_DIV: begin
        if (len_q == '0) state_d = ST_FIN;
        else if (axis_q && stp_q == CntW'(DivSteps - 1)) state_d = ST_CNT;
      end
      ST_CNT: begin
        if (!fits || cnt_q == CntW'(MaxSamples)) begin
          state_d = (cnt_q == '0) ? ST_FIN : ST_GEN;
        end
      end
      ST_GEN: begin
        if (sub_q == 3'd5 && (!smp_diff || push_done) && idx_q == cnt_q - 1'b1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:   if (!push_req || push_done) state_d = ST_FLUSH;
      ST_FLUSH: if (flush_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      spacing_q  <= SpacingReset;
      started_q  <= 1'b0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      emit_x_q   <= '0;
      emit_y_q   <= '0;
      owed_q     <= '0;
      new_owed_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      ovf_q      <= 1'b0;
      sub_q      <= '0;
      stp_q      <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      axis_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) spacing_q <= cfg_wdata_i;

      if (move) begin
        out_v_q   <= 1'b1;
        out_x_q   <= pend_x_q;
        out_y_q   <= pend_y_q;
        out_re_q  <= flush_req;
        out_pe_q  <= flush_req && last_q;
        out_ovf_q <= ovf_q;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (push_done) begin
        pend_v_q <= 1'b1;
        pend_x_q <= push_x;
        pend_y_q <= push_y;
        emit_x_q <= push_x;
        emit_y_q <= push_y;
      end else if (flush_done) begin
        pend_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: if (in_acc) begin
          cur_x_q <= point_x_i;
          cur_y_q <= point_y_i;
          last_q  <= last_point_i;
          ovf_q   <= 1'b0;
          ax_q    <= adx[CoordW-1:0];
          ay_q    <= ady[CoordW-1:0];
          negx_q  <= dx[CoordW];
          negy_q  <= dy[CoordW];
          acc_q   <= '0;
          sub_q   <= '0;
          if (!started_q) begin
            started_q  <= 1'b1;
            new_owed_q <= spacing_q;
          end else if (spacing_q == '0) begin
            new_owed_q <= owed_q;
          end else begin
            owed_q     <= (owed_q == '0) ? spacing_q : owed_q;
            new_owed_q <= (owed_q == '0) ? spacing_q : owed_q;
          end
        end
        ST_SQR: begin
          sub_q <= sub_q + 3'd1;
          if (sub_q != 3'd0) begin
            acc_q <= acc_q + (sub_q[0] ? RadW'(prod) : RadW'({prod, 17'b0}));
          end
          rem_q <= '0;
          len_q <= '0;
          stp_q <= '0;
        end
        ST_ROOT: begin
          acc_q <= {acc_q[RadW-3:0], 2'b00};
          rem_q <= rt_ge ? RemW'(rt_t - rt_trial) : RemW'(rt_t);
          len_q <= {len_q[LenW-2:0], rt_ge};
          stp_q <= (stp_q == CntW'(RootSteps - 1)) ? '0 : stp_q + 1'b1;
          axis_q <= 1'b0;
        end
        ST_DIV: begin
          rem_q <= dv_ge ? dv_t - RemW'(len_q) : dv_t;
          qt_q  <= {qt_q[QW-2:0], dv_ge};
          if (stp_q == CntW'(DivSteps - 1)) begin
            stp_q <= '0;
            axis_q <= 1'b1;
            if (axis_q) qy_q <= {qt_q[QW-2:0], dv_ge};
            else qx_q <= {qt_q[QW-2:0], dv_ge};
          end else begin
            stp_q <= stp_q + 1'b1;
          end
          used_q <= '0;
          cnt_q  <= '0;
        end
        ST_CNT: begin
          if (fits && cnt_q != CntW'(MaxSamples)) begin
            cnt_q  <= cnt_q + 1'b1;
            used_q <= nxt;
          end else begin
            if (fits) begin
              ovf_q      <= 1'b1;
              new_owed_q <= spacing_q;
            end else begin
              new_owed_q <= owed_cur - left[SpacingW-1:0];
            end
            used_q <= UsedW'(owed_q);
            idx_q  <= '0;
            sub_q  <= '0;
          end
        end
        ST_GEN: begin
          unique case (sub_q) inside
            3'd1, 3'd3: begin
              acc_q <= RadW'(prod);
              sub_q <= sub_q + 3'd1;
            end
            3'd2: begin
              sx_q  <= along[CoordW-1:0];
              sub_q <= sub_q + 3'd1;
            end
            3'd4: begin
              sy_q  <= along[CoordW-1:0];
              sub_q <= sub_q + 3'd1;
            end
            3'd5: begin
              if (!smp_diff || push_done) begin
                sub_q  <= '0;
                idx_q  <= idx_q + 1'b1;
                used_q <= used_q + UsedW'(spacing_q);
              end
            end
            default: sub_q <= sub_q + 3'd1;
          endcase
        end
        ST_FLUSH: if (flush_done) begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          owed_q   <= new_owed_q;
          if (last_q) started_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign res_x_o     = out_x_q;
  assign res_y_o     = out_y_q;
  assign run_end_o   = out_re_q;
  assign path_end_o  = out_pe_q;
  assign overflow_o  = out_ovf_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over while idle");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSamples))
    else $error("sample count beyond limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && state_q == ST_GEN) |-> (cnt_q == CntW'(MaxSamples)))
    else $error("overflow without full sample count");

  a_gen_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (len_q != '0 && cnt_q != '0))
    else $error("sample generation on empty segment");

  a_path_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_pe_q) |-> out_re_q)
    else $error("path end without run end");

endmodule

@@ test/uniform_polyline_resampler_unit_test.sv @@
// Testbench for uniform_polyline_resampler_unit: directed and random polylines
// checked item by item against an in-bench arc-length resampling predictor.
// Depends on uprs_pkg and the resampler RTL.
`timescale 1ns / 1ps

module uniform_polyline_resampler_unit_test;
  import uprs_pkg::*;

  localparam int QuietLimit = 8000;
  localparam int SettleCycles = 900;
  localparam longint unsigned MaxSpacing = 64'h7FFF_FFFF;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     run_end;
    logic                     path_end;
    logic                     ovf;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CoordW-1:0] res_x_o, res_y_o;
  logic run_end_o, path_end_o, overflow_o;
  logic cfg_we_i = 1'b0;
  logic [SpacingW-1:0] cfg_wdata_i = '0;

  uniform_polyline_resampler_unit uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned spacing;
  bit started;
  longint prev_x, prev_y, emit_x, emit_y;
  longint unsigned owed;
  sample_t pending_samples[$];
  int errors = 0;
  int quiet = 0;
  bit driving = 1'b1;

  function automatic longint unsigned isqrt(longint unsigned ax, longint unsigned ay);
    logic [67:0] sum, c2;
    logic [33:0] r, c;
    sum = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      c2 = 68'(c) * 68'(c);
      if (c2 <= sum) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint step_along(longint s, longint d, longint unsigned q,
                                        longint unsigned c);
    longint unsigned off;
    off = (q * c + (64'd1 << (DirBits - 1))) >> DirBits;
    return d < 0 ? s - longint'(off) : s + longint'(off);
  endfunction

  task automatic resample_vertex(input logic signed [CoordW-1:0] px,
                                 input logic signed [CoordW-1:0] py, input logic lst);
    sample_t outs[$];
    sample_t s;
    longint x, y, dx, dy, sx, sy;
    longint unsigned ax, ay, len, qx, qy, used, left;
    int count;
    bit ovf;
    x = px;
    y = py;
    ovf = 0;
    if (!started) begin
      s = '0; s.x = px; s.y = py; outs.insert(outs.size(), s);
      emit_x = x; emit_y = y;
      owed = spacing;
      started = 1;
    end else if (spacing == 0) begin
      s = '0; s.x = px; s.y = py; outs.insert(outs.size(), s);
      emit_x = x; emit_y = y;
    end else begin
      dx = x - prev_x;
      dy = y - prev_y;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      len = isqrt(ax, ay);
      if (owed == 0) owed = spacing;
      if (len > 0) begin
        qx = (ax << DirBits) / len;
        qy = (ay << DirBits) / len;
        used = 0;
        count = 0;
        while (used + owed <= len) begin
          if (count >= MaxSamples) begin
            ovf = 1;
            break;
          end
          count++;
          used += owed;
          sx = step_along(prev_x, dx, qx, used);
          sy = step_along(prev_y, dy, qy, used);
          if (sx != emit_x || sy != emit_y) begin
            s = '0; s.x = sx[31:0]; s.y = sy[31:0]; outs.insert(outs.size(), s);
            emit_x = sx; emit_y = sy;
          end
          owed = spacing;
        end
        if (ovf) owed = spacing;
        else begin
          left = len > used ? len - used : 0;
          if (owed <= left) owed = spacing;
          else owed -= left;
        end
      end
    end
    prev_x = x;
    prev_y = y;
    if (lst) begin
      if (x != emit_x || y != emit_y) begin
        s = '0; s.x = px; s.y = py; outs.insert(outs.size(), s);
        emit_x = x; emit_y = y;
      end
      started = 0;
    end
    foreach (outs[k]) begin
      outs[k].ovf = ovf;
      if (k == outs.size() - 1) begin
        outs[k].run_end = 1'b1;
        outs[k].path_end = lst;
      end
      pending_samples.insert(pending_samples.size(), outs[k]);
    end
  endtask

  task automatic send_vertex(input logic signed [CoordW-1:0] px,
                             input logic signed [CoordW-1:0] py, input logic lst);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_x_i <= px;
    point_y_i <= py;
    last_point_i <= lst;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    resample_vertex(px, py, lst);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_spacing(input longint unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[SpacingW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spacing = v & MaxSpacing;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result side: random stalls, then field-by-field compare
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    sample_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        report("unexpected item x", res_x_o, 0);
      end else begin
        want = pending_samples.pop_front();
        if (res_x_o !== want.x) report("res_x", res_x_o, want.x);
        if (res_y_o !== want.y) report("res_y", res_y_o, want.y);
        if (run_end_o !== want.run_end) report("run_end", run_end_o, want.run_end);
        if (path_end_o !== want.path_end) report("path_end", path_end_o, want.path_end);
        if (overflow_o !== want.ovf) report("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_extremes;
    set_spacing(65536);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_vertex(0, 0, 1'b1);
    set_spacing(MaxSpacing);
    send_vertex(32'sh8000_0000, 0, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 0, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
  endtask

  task automatic test_special_cases;
    set_spacing(100);
    send_vertex(0, 0, 1'b0);
    send_vertex(300, 0, 1'b0);
    send_vertex(300, 0, 1'b0);
    send_vertex(300, 250, 1'b0);
    send_vertex(-300, -250, 1'b1);
    set_spacing(1);
    send_vertex(10, 10, 1'b0);
    send_vertex(10, 10, 1'b1);
    send_vertex(1000, -7, 1'b0);
    send_vertex(5, 300, 1'b1);
  endtask

  task automatic test_pass_through;
    set_spacing(0);
    send_vertex(5, 5, 1'b0);
    send_vertex(5, 5, 1'b0);
    send_vertex(-9, 40, 1'b0);
    set_spacing(50);
    send_vertex(200, 40, 1'b0);
    send_vertex(200, 40, 1'b1);
  endtask

  task automatic test_random_paths(input int items);
    longint x, y, r;
    int k, plen;
    logic lst;
    k = 0;
    while (k < items) begin
      if (k % 80 == 0) begin
        case ($urandom_range(0, 5))
          0: set_spacing(0);
          1: set_spacing(1);
          2: set_spacing(MaxSpacing);
          3: set_spacing($urandom_range(1, 2000));
          4: set_spacing(65536);
          default: set_spacing($urandom);
        endcase
      end
      plen = $urandom_range(1, 8);
      x = $signed($urandom);
      y = $signed($urandom);
      r = spacing == 0 ? 1000 : longint'(spacing) * 4;
      if (r > 64'sd1073741823) r = 64'sd1073741823;
      for (int i = 0; i < plen; i++) begin
        lst = (i == plen - 1);
        if (i > 0) begin
          case ($urandom_range(0, 9))
            0: begin x = $signed($urandom); y = $signed($urandom); end
            1: ;
            default: begin
              x += longint'($urandom_range(0, 2 * r)) - r;
              y += longint'($urandom_range(0, 2 * r)) - r;
            end
          endcase
          x = longint'($signed(x[31:0]));
          y = longint'($signed(y[31:0]));
        end
        send_vertex(x[31:0], y[31:0], lst);
        k++;
      end
    end
  endtask

  initial begin
    spacing = 65536;
    started = 0;
    prev_x = 0; prev_y = 0; emit_x = 0; emit_y = 0; owed = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_pass_through();
    test_random_paths(386);
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/uprs_pkg.sv
sv/uprs_mul.sv
sv/uniform_polyline_resampler_unit.sv
test/uniform_polyline_resampler_unit_test.sv
